[rtl/tbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tbt_pkg;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned SecondsW = 16;
  // Ten ticks per second times the widest timeout still fits in 20 bits.
  localparam int unsigned TicksW   = 20;

  typedef enum logic [ActionW-1:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_POST    = 3'd2,
    ACT_EXIT    = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_QUERY   = 3'd5
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [SlotW-1:0]    slot;
    logic [SecondsW-1:0] timeout_seconds;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [SlotW-1:0] slot_out;
    logic             still_blocking;
  } rsp_t;

  // One timer entry: the tick threshold (ten times the seconds) and the ticks seen.
  typedef struct packed {
    logic [TicksW-1:0] limit;
    logic [TicksW-1:0] elapsed;
  } entry_t;

  typedef struct packed {
    logic [TicksW-1:0] elapsed;
    logic              unblock;
  } tick_res_t;

endpackage

`default_nettype wire

[rtl/tbt_tick_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbt_tick_unit (
  input  tbt_pkg::entry_t    entry_i,
  input  logic               exiting_i,
  output tbt_pkg::tick_res_t res_o
);
  import tbt_pkg::*;

  logic [TicksW-1:0] elapsed_next;

  // Elapsed time saturates at the threshold.
  assign elapsed_next = (entry_i.elapsed < entry_i.limit) ?
                        entry_i.elapsed + TicksW'(1) : entry_i.elapsed;

  assign res_o.elapsed = elapsed_next;
  assign res_o.unblock = (elapsed_next >= entry_i.limit) && !exiting_i;

endmodule

`default_nettype wire

[rtl/timeout_block_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Table of timed blocking slots. A command beat is taken when start is high and
// busy is low, and exactly one result beat follows, shown on rsp_o for one cycle
// with valid_o high; the receiver cannot stall it, so it must take every result
// beat as it comes. Destroy, post, mark exiting, query and unknown actions answer
// in the cycle after the command. Create walks the used flags one slot per cycle
// from slot 0 until it finds a free one, and answers with an error when the table
// is full; a create with zero seconds answers with an error in the cycle after
// the command. A tick walks every slot through the timer memory read port and the
// shared increment-and-compare unit, one slot per cycle with a registered read
// ahead of it. Busy stays high until the result beat has been issued.
// No clearing pass is needed after reset: a tick reads the timer memory for
// every slot, but only uses the entry of a slot whose used flag is set, and
// create always writes the entry first.
module timeout_block_table_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tbt_pkg::req_t req_i,
  output logic          valid_o,
  output tbt_pkg::rsp_t rsp_o
);
  import tbt_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FIND = 3'b010,
    ST_TICK = 3'b100
  } state_e;

  // Control state.
  state_e           state_d, state_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             pv_d, pv_q;
  logic [IdxW-1:0]  pidx_d, pidx_q;
  logic [SLOTS-1:0] used_d, used_q;
  logic [SLOTS-1:0] blk_d, blk_q;
  logic [SLOTS-1:0] exit_d, exit_q;
  logic             valid_d, valid_q;

  // Payload registers.
  req_t             req_d, req_q;
  rsp_t             rsp_d, rsp_q;
  entry_t           rd_data_q;

  // Timer memory, one entry per slot.
  entry_t           mem_q [SLOTS];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  entry_t           mem_wdata;
  logic             rd_en;
  logic [IdxW-1:0]  rd_idx;

  logic             in_ok, in_blk;
  logic [IdxW-1:0]  in_idx;
  logic             q_ok;
  logic [IdxW-1:0]  q_idx;
  logic [IdxW-1:0]  scan_idx;
  logic             scan_end;
  logic [TicksW-1:0] limit_new;
  tick_res_t        tick_res;

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Addressed slot of the incoming command and of the held command.
  assign in_idx = IdxW'(req_i.slot);
  assign in_ok  = (32'(req_i.slot) < SLOTS) && used_q[in_idx];
  assign in_blk = blk_q[in_idx];
  assign q_idx  = IdxW'(req_q.slot);
  assign q_ok   = (32'(req_q.slot) < SLOTS) && used_q[q_idx];

  assign scan_idx = cnt_q[IdxW-1:0];
  assign scan_end = (cnt_q == CntW'(SLOTS));

  // Threshold in ticks: seconds times ten, as two shifted copies added.
  assign limit_new = (TicksW'(req_q.timeout_seconds) << 3) +
                     (TicksW'(req_q.timeout_seconds) << 1);

  // The tick walk reads slot cnt_q and, in the next cycle, updates slot pidx_q.
  assign rd_en  = (state_q == ST_TICK) && !scan_end;
  assign rd_idx = scan_idx;

  tbt_tick_unit u_tick (
    .entry_i   (rd_data_q),
    .exiting_i (exit_q[pidx_q]),
    .res_o     (tick_res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    used_d    = used_q;
    blk_d     = blk_q;
    exit_d    = exit_q;
    valid_d   = 1'b0;
    req_d     = req_q;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = '{limit: rd_data_q.limit, elapsed: tick_res.elapsed};

    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start) begin
          req_d = req_i;
          // Default answer: error, slot echoed, not blocking.
          rsp_d = '{status: 1'b1, slot_out: req_i.slot, still_blocking: 1'b0};
          case (action_e'(req_i.action))
            ACT_CREATE: begin
              if (req_i.timeout_seconds != '0) begin
                state_d = ST_FIND;
              end else begin
                valid_d = 1'b1;
              end
            end
            ACT_TICK: begin
              state_d = ST_TICK;
            end
            ACT_DESTROY: begin
              valid_d = 1'b1;
              if (in_ok) begin
                used_d[in_idx] = 1'b0;
                blk_d[in_idx]  = 1'b0;
                exit_d[in_idx] = 1'b0;
                rsp_d.status   = 1'b0;
              end
            end
            ACT_POST: begin
              valid_d = 1'b1;
              if (in_ok) begin
                blk_d[in_idx] = 1'b0;
                rsp_d.status  = 1'b0;
              end
            end
            ACT_EXIT: begin
              valid_d = 1'b1;
              if (in_ok) begin
                exit_d[in_idx]       = 1'b1;
                rsp_d.status         = 1'b0;
                rsp_d.still_blocking = in_blk;
              end
            end
            ACT_QUERY: begin
              valid_d = 1'b1;
              if (in_ok) begin
                rsp_d.status         = 1'b0;
                rsp_d.still_blocking = in_blk;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_FIND: begin
        if (scan_end) begin
          // Table full: the error answer is already loaded.
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else if (!used_q[scan_idx]) begin
          used_d[scan_idx] = 1'b1;
          blk_d[scan_idx]  = 1'b1;
          exit_d[scan_idx] = 1'b0;
          mem_we    = 1'b1;
          mem_waddr = scan_idx;
          mem_wdata = '{limit: limit_new, elapsed: '0};
          rsp_d     = '{status: 1'b0, slot_out: SlotW'(scan_idx), still_blocking: 1'b1};
          valid_d   = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      ST_TICK: begin
        if (rd_en) begin
          pv_d   = 1'b1;
          pidx_d = rd_idx;
          cnt_d  = cnt_q + CntW'(1);
        end
        if (pv_q && used_q[pidx_q] && blk_q[pidx_q]) begin
          mem_we = 1'b1;
          if (tick_res.unblock) begin
            blk_d[pidx_q] = 1'b0;
          end
        end
        // Walk finished and last update written: flags are final.
        if (!rd_en && !pv_q) begin
          rsp_d = '{status: 1'b0, slot_out: req_q.slot,
                    still_blocking: q_ok && blk_q[q_idx]};
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
      used_q  <= '0;
      blk_q   <= '0;
      exit_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      pidx_q  <= pidx_d;
      used_q  <= used_d;
      blk_q   <= blk_d;
      exit_q  <= exit_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

endmodule

`default_nettype wire
